[hdl/x64ild_pkg.sv]
`default_nettype none
package x64ild_pkg;

    localparam int POS_W   = 5;
    localparam int REL_W   = 4;
    localparam int TOT_W   = 6;
    localparam int MAX_LEN = 24;

    localparam logic [7:0] OPC_ESC      = 8'h0F;
    localparam logic [7:0] REX_W_BIT    = 8'h08;
    localparam logic [7:0] REX_BASE     = 8'h40;
    localparam logic [7:0] PFX_OPSIZE   = 8'h66;
    localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
    localparam logic [7:0] OPC_GRP_BT   = 8'hBA;
    localparam logic [7:0] OPC_TEST_B   = 8'hF6;
    localparam logic [7:0] OPC_TEST_V   = 8'hF7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;

    typedef enum logic [1:0] {
        IMM_FIXED,
        IMM_IZ,
        IMM_MOV,
        IMM_MOFFS
    } imm_kind_t;

    typedef struct packed {
        logic [63:0] window_low;
        logic [63:0] window_high;
    } x64ild_in_t;

    typedef struct packed {
        logic [4:0] length;
        logic [1:0] status;
    } x64ild_out_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [REL_W-1:0] rel;
        imm_kind_t        kind;
    } lane_res_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic             has66;
        logic             has67;
        logic             rexw;
    } pfx_info_t;

    function automatic logic needs_sib(input logic [7:0] modrm);
        return (modrm[7:6] != 2'd3) && (modrm[2:0] == 3'd4);
    endfunction

    // ModR/M byte plus SIB plus displacement
    function automatic logic [2:0] mrm_size(input logic [7:0] modrm, input logic [7:0] sib);
        logic [2:0] sz;
        sz = 3'd1;
        if (modrm[7:6] != 2'd3)
        begin
            if (modrm[2:0] == 3'd4)
            begin
                sz = sz + 3'd1;
            end
            unique case (modrm[7:6])
                2'd0:
                begin
                    if (modrm[2:0] == 3'd5 || (modrm[2:0] == 3'd4 && sib[2:0] == 3'd5))
                    begin
                        sz = sz + 3'd4;
                    end
                end
                2'd1:    sz = sz + 3'd1;
                default: sz = sz + 3'd4;
            endcase
        end
        return sz;
    endfunction

endpackage
`default_nettype wire

[hdl/x64_instruction_length_decoder_core.sv]
// Sizes the first x86-64 instruction in a code window of up to 16 bytes.
// The result strobe follows the transfer through the lane stage, then the merge stage.
// Throughput: one window per cycle; busy stays low since both stages always advance.
// The opcode lane at each byte position and the prefix scan set the first stage.
// Reset (rst_n low, asynchronous) drops any window in flight; no result strobes.
`default_nettype none
module x64_instruction_length_decoder_core
    import x64ild_pkg::*;
#(
    parameter int WINDOW_BYTES = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire x64ild_in_t  cmd,
    output logic             done,
    output x64ild_out_t      result
);

    localparam int WIN = WINDOW_BYTES;
    localparam int PAD = WIN + 3;

    logic [127:0] win_flat;
    logic [7:0]   bytes [PAD];
    logic [7:0]   scan  [WIN];
    lane_res_t    lane_res [WIN];
    lane_res_t    lane_reg [WIN];
    pfx_info_t    pfx_info;
    pfx_info_t    pfx_reg;
    logic         v1_reg;
    logic         v1_next;
    x64ild_out_t  merged;
    x64ild_out_t  out_reg;
    logic         done_reg;
    logic         done_next;

    assign win_flat = {cmd.window_high, cmd.window_low};
    assign busy     = 1'b0;

    genvar j;
    generate
        for (j = 0; j < PAD; j++)
        begin : g_byte
            if (j < 16)
            begin : g_win
                assign bytes[j] = win_flat[8*j +: 8];
            end
            else
            begin : g_zero
                assign bytes[j] = 8'h00;
            end
        end

        for (j = 0; j < WIN; j++)
        begin : g_lane
            assign scan[j] = bytes[j];
            x64ild_lane #(
                .WIN (WIN),
                .POS (j)
            ) u_lane (
                .bytes ({bytes[j+3], bytes[j+2], bytes[j+1], bytes[j]}),
                .res   (lane_res[j])
            );
        end
    endgenerate

    x64ild_prefix #(
        .WIN (WIN)
    ) u_prefix (
        .scan (scan),
        .info (pfx_info)
    );

    // Hold lane results on each transfer
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            lane_reg <= lane_res;
            pfx_reg  <= pfx_info;
        end
    end

    x64ild_merge #(
        .WIN (WIN)
    ) u_merge (
        .lanes (lane_reg),
        .info  (pfx_reg),
        .res   (merged)
    );

    assign v1_next   = start && !busy;
    assign done_next = v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            out_reg <= merged;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

[hdl/x64ild_lane.sv]
`default_nettype none
module x64ild_lane
    import x64ild_pkg::*;
#(
    parameter int WIN = 16,
    parameter int POS = 0
)(
    input  wire logic [31:0] bytes,
    output lane_res_t        res
);

    localparam bit HAS1 = (POS + 1) < WIN;
    localparam bit HAS2 = (POS + 2) < WIN;
    localparam bit HAS3 = (POS + 3) < WIN;

    logic [7:0] op;
    logic [7:0] n1;
    logic [7:0] n2;
    logic [7:0] n3;
    logic [REL_W-1:0] mrm1;
    logic [REL_W-1:0] mrm2;
    logic ovf1;
    logic ovf2;

    assign op = bytes[7:0];
    assign n1 = bytes[15:8];
    assign n2 = bytes[23:16];
    assign n3 = bytes[31:24];

    // ModR/M right after the opcode, or after the escape and second opcode byte
    assign mrm1 = {1'b0, mrm_size(n1, n2)};
    assign mrm2 = {1'b0, mrm_size(n2, n3)};
    assign ovf1 = !HAS1 || (needs_sib(n1) && !HAS2);
    assign ovf2 = !HAS2 || (needs_sib(n2) && !HAS3);

    always_comb
    begin
        res.status = ST_OK;
        res.rel    = '0;
        res.kind   = IMM_FIXED;
        if (op == OPC_ESC)
        begin
            if (!HAS1)
            begin
                res.status = ST_OVERRUN;
            end
            else if (n1[7:4] == 4'h8)
            begin
                res.rel = 4'd6;
            end
            else if (n1 == 8'h05)
            begin
                res.rel = 4'd2;
            end
            else if (n1 == OPC_GRP_BT)
            begin
                if (ovf2) res.status = ST_OVERRUN;
                else      res.rel = 4'd3 + mrm2;
            end
            else if (n1 == 8'h1F || n1[7:4] == 4'h4 || n1 == 8'hB6 || n1 == 8'hB7 ||
                     n1 == 8'hBE || n1 == 8'hBF || n1 == 8'hAF)
            begin
                if (ovf2) res.status = ST_OVERRUN;
                else      res.rel = 4'd2 + mrm2;
            end
            else
            begin
                res.status = ST_UNKNOWN;
            end
        end
        else if (op == 8'h90 || op == 8'hCC || op == 8'hC3 || op[7:4] == 4'h5)
        begin
            res.rel = 4'd1;
        end
        else if (op == 8'hC2)
        begin
            res.rel = 4'd3;
        end
        else if (op[7:3] == 5'b10111)
        begin
            res.rel  = 4'd1;
            res.kind = IMM_MOV;
        end
        else if (op[7:3] == 5'b10110 || op == 8'hEB || op[7:4] == 4'h7 ||
                 op == 8'hA8 || op == 8'h6A || (op & 8'hC7) == 8'h04)
        begin
            res.rel = 4'd2;
        end
        else if (op == 8'hE8 || op == 8'hE9)
        begin
            res.rel = 4'd5;
        end
        else if (op == 8'hA9 || op == 8'h68 || (op & 8'hC7) == 8'h05)
        begin
            res.rel  = 4'd1;
            res.kind = IMM_IZ;
        end
        else if (op[7:2] == 6'b101000)
        begin
            res.rel  = 4'd1;
            res.kind = IMM_MOFFS;
        end
        else if (op == 8'h80 || op == 8'h83 || op == 8'hC6 || op == 8'hC0 || op == 8'hC1)
        begin
            if (ovf1) res.status = ST_OVERRUN;
            else      res.rel = 4'd2 + mrm1;
        end
        else if (op == 8'h81 || op == 8'hC7)
        begin
            if (ovf1)
            begin
                res.status = ST_OVERRUN;
            end
            else
            begin
                res.rel  = 4'd1 + mrm1;
                res.kind = IMM_IZ;
            end
        end
        else if (op == OPC_TEST_B || op == OPC_TEST_V)
        begin
            if (ovf1)
            begin
                res.status = ST_OVERRUN;
            end
            else if (n1[5:3] != 3'd0)
            begin
                res.rel = 4'd1 + mrm1;
            end
            else if (op == OPC_TEST_B)
            begin
                res.rel = 4'd2 + mrm1;
            end
            else
            begin
                res.rel  = 4'd1 + mrm1;
                res.kind = IMM_IZ;
            end
        end
        else if ((op & 8'hC4) == 8'h00 || op == 8'hFF || op == 8'h63 || op == 8'h8D ||
                 (op >= 8'h84 && op <= 8'h8B) || op == 8'hD1 || op == 8'hD3 || op == 8'h8F)
        begin
            if (ovf1) res.status = ST_OVERRUN;
            else      res.rel = 4'd1 + mrm1;
        end
        else
        begin
            res.status = ST_UNKNOWN;
        end
    end

endmodule
`default_nettype wire

[hdl/x64ild_prefix.sv]
`default_nettype none
module x64ild_prefix
    import x64ild_pkg::*;
#(
    parameter int WIN = 16
)(
    input  wire logic [7:0] scan [WIN],
    output pfx_info_t       info
);

    function automatic logic is_prefix(input logic [7:0] b);
        return (b[7:4] == REX_BASE[7:4]) || b == PFX_OPSIZE || b == PFX_ADDRSIZE ||
               b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h26 || b == 8'h2E ||
               b == 8'h36 || b == 8'h3E || b == 8'h64 || b == 8'h65;
    endfunction

    // Walk the prefix run; the last REX sets W
    always_comb
    begin
        info = '0;
        for (int j = 0; j < WIN; j++)
        begin
            if (!info.found)
            begin
                if (is_prefix(scan[j]))
                begin
                    if (scan[j][7:4] == REX_BASE[7:4])
                    begin
                        info.rexw = (scan[j] & REX_W_BIT) != 8'h00;
                    end
                    if (scan[j] == PFX_OPSIZE)
                    begin
                        info.has66 = 1'b1;
                    end
                    if (scan[j] == PFX_ADDRSIZE)
                    begin
                        info.has67 = 1'b1;
                    end
                end
                else
                begin
                    info.found = 1'b1;
                    info.pos   = POS_W'(j);
                end
            end
        end
    end

endmodule
`default_nettype wire

[hdl/x64ild_merge.sv]
`default_nettype none
module x64ild_merge
    import x64ild_pkg::*;
#(
    parameter int WIN = 16
)(
    input  wire lane_res_t  lanes [WIN],
    input  wire pfx_info_t  info,
    output x64ild_out_t     res
);

    localparam int IDX_W = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int LIMIT = (WIN < MAX_LEN) ? WIN : MAX_LEN;

    lane_res_t        sel;
    logic [3:0]       iz;
    logic [3:0]       imm;
    logic [TOT_W-1:0] total;

    assign sel = lanes[info.pos[IDX_W-1:0]];
    assign iz  = (info.has66 && !info.rexw) ? 4'd2 : 4'd4;

    always_comb
    begin
        unique case (sel.kind)
            IMM_IZ:    imm = iz;
            IMM_MOV:   imm = info.rexw ? 4'd8 : iz;
            IMM_MOFFS: imm = info.has67 ? 4'd4 : 4'd8;
            default:   imm = 4'd0;
        endcase
    end

    assign total = TOT_W'(info.pos) + TOT_W'(sel.rel) + TOT_W'(imm);

    always_comb
    begin
        res.length = '0;
        if (!info.found)
        begin
            res.status = ST_OVERRUN;
        end
        else if (sel.status != ST_OK)
        begin
            res.status = sel.status;
        end
        else if (total > TOT_W'(LIMIT))
        begin
            res.status = ST_OVERRUN;
        end
        else
        begin
            res.status = ST_OK;
            res.length = total[4:0];
        end
    end

endmodule
`default_nettype wire
